FILE: rtl/kmcs_pkg.sv
// ----------------------------------------------------------------------------
// kmcs_pkg
// shared types and constants of the key matrix change scanner
// ----------------------------------------------------------------------------
package kmcs_pkg;

    localparam int LINE_BITS = 48;
    localparam int ELAPSED_W = 16;
    localparam int INTERVAL_W = 16;
    localparam int KEY_IDX_W = 3;

    localparam logic [ELAPSED_W-1:0]  ELAPSED_TOP    = '1;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd10;

    localparam logic MODE_TICK     = 1'b0;
    localparam logic MODE_SNAPSHOT = 1'b1;

    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_PRESS   = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic tick;      // advance elapsed counter
        logic take;      // load change masks from snapshot
        logic next_pass; // switch from release pass to press pass
        logic next_col;  // current column has nothing left
        logic emit;      // load one event into the output register
        logic kind;      // event kind of the running pass
    } t_kmcs_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic due;        // elapsed count exceeds interval
        logic pend_zero;  // no change left in the running pass
        logic col_hit;    // current column holds a change
        logic out_free;   // output register can take an event
    } t_kmcs_sts;

endpackage

FILE: rtl/key_matrix_change_scanner_unit.sv
// ----------------------------------------------------------------------------
// key_matrix_change_scanner_unit
// keyboard matrix change scanner: ms ticks and line snapshots in, key
// release and press events out
// ----------------------------------------------------------------------------
// channel  | direction | handshake                    | payload
// in       | in        | i_in_valid / o_in_ready      | i_mode, i_raw_lines
// out      | out       | o_out_valid / i_out_ready    | o_event_kind, o_key_row,
//          |           |                              | o_key_column, o_last_event
// cfg      | in        | i_cfg_valid / o_cfg_ready    | i_scan_interval_ms
//
// a tick or an early snapshot is handled in the idle state; a processed snapshot
// runs a release pass and then a press pass, each stepping through the columns
// the search looks at one column per cycle and retires one event per cycle
// into the output register while that register is free
// reset: no key held, elapsed count zero, scan interval 10
// the search stalls while the output register holds an event not yet taken
// ----------------------------------------------------------------------------
module key_matrix_change_scanner_unit #(
    parameter int NUM_COLUMNS = 8,
    parameter int NUM_ROWS    = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_mode,
    input  logic [kmcs_pkg::LINE_BITS-1:0]      i_raw_lines,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_event_kind,
    output logic [kmcs_pkg::KEY_IDX_W-1:0]      o_key_row,
    output logic [kmcs_pkg::KEY_IDX_W-1:0]      o_key_column,
    output logic                                o_last_event,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kmcs_pkg::INTERVAL_W-1:0]     i_scan_interval_ms
);
    import kmcs_pkg::*;

    t_kmcs_cmd cmd;
    t_kmcs_sts sts;

    assign o_cfg_ready = 1'b1;

    kmcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_mode     (i_mode),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    kmcs_dp #(
        .NUM_COLUMNS (NUM_COLUMNS),
        .NUM_ROWS    (NUM_ROWS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_raw_lines        (i_raw_lines),
        .i_cfg_valid        (i_cfg_valid && o_cfg_ready),
        .i_scan_interval_ms (i_scan_interval_ms),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_event_kind       (o_event_kind),
        .o_key_row          (o_key_row),
        .o_key_column       (o_key_column),
        .o_last_event       (o_last_event)
    );

endmodule

FILE: rtl/kmcs_ctrl.sv
// ----------------------------------------------------------------------------
// kmcs_ctrl
// sequencer: item intake, release pass, press pass
// ----------------------------------------------------------------------------
module kmcs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_mode,
    input  kmcs_pkg::t_kmcs_sts i_sts,
    output kmcs_pkg::t_kmcs_cmd o_cmd
);
    import kmcs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_REL  = 2'd1;
    localparam logic [1:0] ST_PRS  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.kind = (r_state == ST_PRS) ? KIND_PRESS : KIND_RELEASE;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_mode == MODE_TICK) begin
                        o_cmd.tick = 1'b1;
                    end else if (i_sts.due) begin
                        o_cmd.take = 1'b1;
                        n_state    = ST_REL;
                    end
                end
            end
            ST_REL, ST_PRS: begin
                if (i_sts.pend_zero) begin
                    if (r_state == ST_REL) begin
                        o_cmd.next_pass = 1'b1;
                        n_state         = ST_PRS;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (!i_sts.col_hit) begin
                    o_cmd.next_col = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/kmcs_dp.sv
// ----------------------------------------------------------------------------
// kmcs_dp
// key matrix state, elapsed counter, change search and event register
// ----------------------------------------------------------------------------
module kmcs_dp #(
    parameter int NUM_COLUMNS = 8,
    parameter int NUM_ROWS    = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  kmcs_pkg::t_kmcs_cmd                 i_cmd,
    output kmcs_pkg::t_kmcs_sts                 o_sts,
    input  logic [kmcs_pkg::LINE_BITS-1:0]      i_raw_lines,
    input  logic                                i_cfg_valid,
    input  logic [kmcs_pkg::INTERVAL_W-1:0]     i_scan_interval_ms,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_event_kind,
    output logic [kmcs_pkg::KEY_IDX_W-1:0]      o_key_row,
    output logic [kmcs_pkg::KEY_IDX_W-1:0]      o_key_column,
    output logic                                o_last_event
);
    import kmcs_pkg::*;

    localparam int CW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam int RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int CELLS = (NUM_COLUMNS * NUM_ROWS > LINE_BITS) ?
                           LINE_BITS : NUM_COLUMNS * NUM_ROWS;
    localparam logic [LINE_BITS-1:0] CELL_MASK = {LINE_BITS{1'b1}} >> (LINE_BITS - CELLS);

    logic [LINE_BITS-1:0]  r_held;
    logic [LINE_BITS-1:0]  r_pend;
    logic [LINE_BITS-1:0]  r_press;
    logic [CW-1:0]         r_col;
    logic [ELAPSED_W-1:0]  r_elapsed;
    logic [INTERVAL_W-1:0] r_interval;
    logic                  r_out_valid;
    logic                  r_kind;
    logic [RW-1:0]         r_row_out;
    logic [CW-1:0]         r_col_out;
    logic                  r_last;

    logic [LINE_BITS-1:0]  now_keys;
    logic [NUM_ROWS-1:0]   col_bits;
    logic [RW-1:0]         hit_row;
    logic                  hit;
    logic [LINE_BITS-1:0]  clr_mask;
    logic [LINE_BITS-1:0]  pend_rest;
    logic                  last_hit;
    logic                  out_free;

    assign now_keys = ~i_raw_lines & CELL_MASK;
    assign out_free = !r_out_valid || i_out_ready;

    // column select and first changed row within it
    always_comb begin
        col_bits = '0;
        clr_mask = '0;
        hit      = 1'b0;
        hit_row  = '0;
        for (int c = 0; c < NUM_COLUMNS; c++) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                if (c * NUM_ROWS + r < LINE_BITS) begin
                    if (r_col == CW'(c)) begin
                        col_bits[r] = r_pend[c * NUM_ROWS + r];
                    end
                end
            end
        end
        for (int r = NUM_ROWS - 1; r >= 0; r--) begin
            if (col_bits[r]) begin
                hit     = 1'b1;
                hit_row = RW'(r);
            end
        end
        for (int c = 0; c < NUM_COLUMNS; c++) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                if (c * NUM_ROWS + r < LINE_BITS) begin
                    clr_mask[c * NUM_ROWS + r] = (r_col == CW'(c)) && (hit_row == RW'(r));
                end
            end
        end
    end

    assign pend_rest = r_pend & ~clr_mask;
    // last of the run: nothing left here, and no press pass to follow
    assign last_hit  = (pend_rest == '0) && ((i_cmd.kind == KIND_PRESS) || (r_press == '0));

    assign o_sts.due       = r_elapsed > r_interval;
    assign o_sts.pend_zero = (r_pend == '0);
    assign o_sts.col_hit   = hit;
    assign o_sts.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_pend      <= '0;
            r_press     <= '0;
            r_col       <= '0;
            r_elapsed   <= '0;
            r_interval  <= INTERVAL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_interval <= i_scan_interval_ms;
            end
            if (i_cmd.tick && (r_elapsed != ELAPSED_TOP)) begin
                r_elapsed <= r_elapsed + 1'b1;
            end
            if (i_cmd.take) begin
                r_elapsed <= r_elapsed - r_interval;
                r_pend    <= r_held & ~now_keys;
                r_press   <= now_keys & ~r_held;
                r_held    <= now_keys;
                r_col     <= '0;
            end
            if (i_cmd.next_pass) begin
                r_pend <= r_press;
                r_col  <= '0;
            end
            if (i_cmd.next_col) begin
                r_col <= r_col + 1'b1;
            end
            if (i_cmd.emit) begin
                r_pend      <= pend_rest;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_kind    <= i_cmd.kind;
            r_row_out <= hit_row;
            r_col_out <= r_col;
            r_last    <= last_hit;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_kind;
    assign o_key_row    = KEY_IDX_W'(r_row_out);
    assign o_key_column = KEY_IDX_W'(r_col_out);
    assign o_last_event = r_last;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("event loaded over a waiting event");

    a_emit_one_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> ($countones(r_pend) == $countones($past(r_pend)) - 1))
        else $error("emit did not retire exactly one change");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && last_hit && (i_cmd.kind == KIND_PRESS)) |=> (r_pend == '0))
        else $error("changes left after last event");

    a_held_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held & ~CELL_MASK) == '0)
        else $error("held matrix has bits beyond the cells");

endmodule
